FILE: src/fqts_pkg.sv
// Shared constants, types and control structs for the FASTQ record trim scanner.
// Used by every module of the scanner; depends on nothing.
`default_nettype none

package fqts_pkg;

  // Longest read the counters follow before they saturate.
  localparam longint unsigned MAX_READ_LENGTH = 65535;
  localparam int CountW = $clog2(MAX_READ_LENGTH + 1);

  typedef logic [CountW-1:0] count_t;
  localparam count_t MaxCount = count_t'(MAX_READ_LENGTH);

  // Width of the record fields on the result channel.
  localparam int FieldW = 16;
  typedef logic [FieldW-1:0] field_t;

  // Character codes.
  localparam logic [7:0] ChNewline  = 8'd10;
  localparam logic [7:0] ChHeader   = 8'd64;
  localparam logic [7:0] ChPlus     = 8'd43;
  localparam logic [7:0] ChN        = 8'd78;
  localparam logic [7:0] SangerLow  = 8'd33;
  localparam logic [7:0] SangerHigh = 8'd58;

  // Line kind codes.
  localparam logic [1:0] LkIdle = 2'd0;
  localparam logic [1:0] LkSeq  = 2'd1;
  localparam logic [1:0] LkQual = 2'd2;

  // Per-item control decisions from the line controller.
  typedef struct packed {
    logic take_base;
    logic take_qual;
    logic clear_rec;
    logic file_reset;
    logic end_line;
    logic emit;
    logic final_rec;
  } ctl_t;

  // Record counter status toward the line controller.
  typedef struct packed {
    logic counts_match;
    logic counts_nonzero;
  } rec_status_t;

endpackage

`default_nettype wire

FILE: src/fqts_line_ctrl.sv
// Line classifier of the FASTQ record trim scanner: tracks line kind and line start.
// Depends on fqts_pkg for codes and the control structs.
`default_nettype none

module fqts_line_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire  [7:0]           data_byte,
  input  wire                  end_of_stream,
  input  fqts_pkg::rec_status_t rec_status,
  output fqts_pkg::ctl_t       ctl
);

  logic [1:0] line_kind;
  logic [1:0] line_kind_next;
  logic       at_line_start;
  logic       at_line_start_next;
  logic       skip_line;
  logic       skip_line_next;
  logic       take;

  // Decide what the current byte does and where the line state goes.
  always_comb begin
    ctl                = '0;
    take               = 1'b0;
    line_kind_next     = line_kind;
    at_line_start_next = at_line_start;
    skip_line_next     = skip_line;
    if (end_of_stream) begin
      // Flush the last record and start over as a new file.
      ctl.emit           = rec_status.counts_match && rec_status.counts_nonzero;
      ctl.final_rec      = 1'b1;
      ctl.file_reset     = 1'b1;
      line_kind_next     = fqts_pkg::LkIdle;
      at_line_start_next = 1'b1;
      skip_line_next     = 1'b0;
    end else if (data_byte == fqts_pkg::ChNewline) begin
      ctl.end_line       = 1'b1;
      at_line_start_next = 1'b1;
      skip_line_next     = 1'b0;
    end else if (at_line_start) begin
      at_line_start_next = 1'b0;
      skip_line_next     = 1'b0;
      if (data_byte == fqts_pkg::ChHeader && rec_status.counts_match) begin
        line_kind_next = fqts_pkg::LkSeq;
        skip_line_next = 1'b1;
        ctl.emit       = rec_status.counts_nonzero;
        ctl.clear_rec  = 1'b1;
      end else if (data_byte == fqts_pkg::ChPlus && line_kind == fqts_pkg::LkSeq) begin
        line_kind_next = fqts_pkg::LkQual;
        skip_line_next = 1'b1;
      end else if (line_kind != fqts_pkg::LkSeq && line_kind != fqts_pkg::LkQual) begin
        skip_line_next = 1'b1;
      end else begin
        take = 1'b1;
      end
    end else begin
      take = !skip_line;
    end
    ctl.take_base = take && (line_kind == fqts_pkg::LkSeq);
    ctl.take_qual = take && (line_kind == fqts_pkg::LkQual);
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_kind     <= fqts_pkg::LkIdle;
      at_line_start <= 1'b1;
      skip_line     <= 1'b0;
    end else if (step) begin
      line_kind     <= line_kind_next;
      at_line_start <= at_line_start_next;
      skip_line     <= skip_line_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/fqts_record_tracker.sv
// Per-record base and quality counters and the non-N trim window.
// Depends on fqts_pkg for count types and the control structs.
`default_nettype none

module fqts_record_tracker (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   step,
  input  wire  [7:0]            data_byte,
  input  fqts_pkg::ctl_t        ctl,
  output fqts_pkg::rec_status_t rec_status,
  output fqts_pkg::field_t      read_length,
  output fqts_pkg::field_t      trim_start,
  output fqts_pkg::field_t      trim_length,
  output logic                  length_overflow
);

  fqts_pkg::count_t base_count;
  fqts_pkg::count_t qual_count;
  fqts_pkg::count_t first_real_base;
  fqts_pkg::count_t last_real_base;
  logic             seen_real_base;
  logic             overflow_seen;
  fqts_pkg::count_t window_len;

  // Counter updates; a header with matching counts or end of stream clears the record.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_count      <= '0;
      qual_count      <= '0;
      first_real_base <= '0;
      last_real_base  <= '0;
      seen_real_base  <= 1'b0;
      overflow_seen   <= 1'b0;
    end else if (step) begin
      if (ctl.file_reset || ctl.clear_rec) begin
        base_count      <= '0;
        qual_count      <= '0;
        first_real_base <= '0;
        last_real_base  <= '0;
        seen_real_base  <= 1'b0;
        overflow_seen   <= 1'b0;
      end else if (ctl.take_base) begin
        if (base_count >= fqts_pkg::MaxCount) begin
          overflow_seen <= 1'b1;
        end else begin
          if (data_byte != fqts_pkg::ChN) begin
            if (!seen_real_base) begin
              first_real_base <= base_count;
              seen_real_base  <= 1'b1;
            end
            last_real_base <= base_count;
          end
          base_count <= base_count + fqts_pkg::count_t'(1);
        end
      end else if (ctl.take_qual) begin
        if (qual_count >= fqts_pkg::MaxCount) begin
          overflow_seen <= 1'b1;
        end else begin
          qual_count <= qual_count + fqts_pkg::count_t'(1);
        end
      end
    end
  end

  // Record status and the trim window of the record as it stands.
  always_comb begin
    rec_status.counts_match   = (base_count == qual_count);
    rec_status.counts_nonzero = (base_count != '0);
    window_len      = last_real_base - first_real_base + fqts_pkg::count_t'(1);
    read_length     = fqts_pkg::field_t'(base_count);
    length_overflow = overflow_seen;
    if (seen_real_base && last_real_base >= first_real_base) begin
      trim_start  = fqts_pkg::field_t'(first_real_base);
      trim_length = fqts_pkg::field_t'(window_len);
    end else begin
      trim_start  = '0;
      trim_length = fqts_pkg::field_t'(1);
    end
  end

endmodule

`default_nettype wire

FILE: src/fqts_quality_stats.sv
// File-wide quality statistics: min, max, Sanger detection and freezing.
// Depends on fqts_pkg for character codes and the control struct.
`default_nettype none

module fqts_quality_stats (
  input  wire            clk,
  input  wire            rst,
  input  wire            step,
  input  wire  [7:0]     data_byte,
  input  fqts_pkg::ctl_t ctl,
  output logic [7:0]     low_quality,
  output logic [7:0]     high_quality,
  output logic           sanger_scale
);

  logic [7:0] lowest_quality;
  logic [7:0] highest_quality;
  logic       sanger_seen;
  logic       stats_frozen;

  // Statistics follow quality bytes until the line with the first Sanger symbol ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_quality  <= 8'hFF;
      highest_quality <= 8'h00;
      sanger_seen     <= 1'b0;
      stats_frozen    <= 1'b0;
    end else if (step) begin
      if (ctl.file_reset) begin
        lowest_quality  <= 8'hFF;
        highest_quality <= 8'h00;
        sanger_seen     <= 1'b0;
        stats_frozen    <= 1'b0;
      end else begin
        if (ctl.take_qual && !stats_frozen) begin
          if (data_byte < lowest_quality) begin
            lowest_quality <= data_byte;
          end
          if (data_byte > highest_quality) begin
            highest_quality <= data_byte;
          end
          if (data_byte >= fqts_pkg::SangerLow && data_byte <= fqts_pkg::SangerHigh) begin
            sanger_seen <= 1'b1;
          end
        end
        if (ctl.end_line && sanger_seen) begin
          stats_frozen <= 1'b1;
        end
      end
    end
  end

  assign low_quality  = lowest_quality;
  assign high_quality = highest_quality;
  assign sanger_scale = sanger_seen;

endmodule

`default_nettype wire

FILE: src/fastq_record_trim_scanner_top.sv
// Top level of the FASTQ record trim scanner: input register, result register, glue.
// Depends on fqts_pkg, fqts_line_ctrl, fqts_record_tracker and fqts_quality_stats.
//
// Usage:
//   The item channel (item_valid, item_stall, data_byte, end_of_stream) carries one
//   file byte per transfer, or an end-of-stream marker that flushes the last record.
//   The result channel (result_valid, result_stall and the record fields) carries one
//   transfer per finished record: at each header that follows a non-empty record with
//   matching counts and at an end-of-stream marker whose base and quality counts match and are not zero.
//   Each byte goes through an input register, the compare and counter logic, and, if it
//   finishes a record, a result register.
//   Unless the receiver stalls, one byte is taken every cycle; throughput is one item
//   per cycle, set by the single state update per byte in the scanning stage.
//   When the receiver stalls, a waiting result holds and the scanning stage stops;
//   item_stall rises only once the input register is also full, so the block still
//   takes one byte while a result waits.
//   Synchronous reset clears the line state, the record counts and the quality
//   statistics, and empties both registers. After an end-of-stream marker the line
//   state, record counts and statistics return to reset values, so the next byte begins a new file.
`default_nettype none

module fastq_record_trim_scanner_top (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     item_valid,
  output logic                    item_stall,
  input  wire  [7:0]              data_byte,
  input  wire                     end_of_stream,
  output logic                    result_valid,
  input  wire                     result_stall,
  output logic [15:0]             read_length,
  output logic [15:0]             trim_start,
  output logic [15:0]             trim_length,
  output logic [7:0]              low_quality,
  output logic [7:0]              high_quality,
  output logic                    sanger_scale,
  output logic                    final_record,
  output logic                    length_overflow
);

  logic                  in_full;
  logic [7:0]            in_byte;
  logic                  in_eos;
  logic                  step;
  fqts_pkg::ctl_t        ctl;
  fqts_pkg::rec_status_t rec_status;
  fqts_pkg::field_t      rec_read_length;
  fqts_pkg::field_t      rec_trim_start;
  fqts_pkg::field_t      rec_trim_length;
  logic                  rec_overflow;
  logic [7:0]            st_min;
  logic [7:0]            st_max;
  logic                  st_sanger;

  // The scanning stage moves when it holds a byte and the result register can take a new result.
  assign step       = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && result_valid && result_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_byte <= data_byte;
      in_eos  <= end_of_stream;
    end
  end

  fqts_line_ctrl u_line_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .end_of_stream (in_eos),
    .rec_status    (rec_status),
    .ctl           (ctl)
  );

  fqts_record_tracker u_record_tracker (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (in_byte),
    .ctl             (ctl),
    .rec_status      (rec_status),
    .read_length     (rec_read_length),
    .trim_start      (rec_trim_start),
    .trim_length     (rec_trim_length),
    .length_overflow (rec_overflow)
  );

  fqts_quality_stats u_quality_stats (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (in_byte),
    .ctl          (ctl),
    .low_quality  (st_min),
    .high_quality (st_max),
    .sanger_scale (st_sanger)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && ctl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload, captured from the state as it stood before this byte.
  always_ff @(posedge clk) begin
    if (step && ctl.emit) begin
      read_length     <= rec_read_length;
      trim_start      <= rec_trim_start;
      trim_length     <= rec_trim_length;
      low_quality     <= st_min;
      high_quality    <= st_max;
      sanger_scale    <= st_sanger;
      final_record    <= ctl.final_rec;
      length_overflow <= rec_overflow;
    end
  end

  // The trim window lies inside the read.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, trim_start} + {1'b0, trim_length} <= {1'b0, read_length}))
    else $error("trim window exceeds read length");

  // Min and max are either untouched or ordered.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((low_quality <= high_quality) ||
                      (low_quality == 8'hFF && high_quality == 8'h00)))
    else $error("quality statistics out of order");

  // A result never leaves the register while the receiver stalls it.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(read_length) &&
                                        $stable(final_record)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: dv/fqts_record_checker.sv
// Record checker for the FASTQ record trim scanner: watches both channels, predicts each
// trim report from the accepted bytes and compares it with the result channel.
// Depends on fqts_pkg for the character codes, line kinds and count type.
module fqts_record_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         item_valid,
  input  wire         item_stall,
  input  wire  [7:0]  data_byte,
  input  wire         end_of_stream,
  input  wire         result_valid,
  input  wire         result_stall,
  input  wire  [15:0] read_length,
  input  wire  [15:0] trim_start,
  input  wire  [15:0] trim_length,
  input  wire  [7:0]  low_quality,
  input  wire  [7:0]  high_quality,
  input  wire         sanger_scale,
  input  wire         final_record,
  input  wire         length_overflow,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    fqts_pkg::field_t bases;
    fqts_pkg::field_t start;
    fqts_pkg::field_t span;
    logic [7:0]       q_min;
    logic [7:0]       q_max;
    logic             sanger;
    logic             flushed;
    logic             saturated;
  } trim_report_t;

  // Reports predicted but not yet seen on the result channel, oldest first.
  trim_report_t report_q[$];

  // Scanner state as the checker sees it.
  logic [1:0]       line_kind;
  logic             at_start;
  logic             skip_rest;
  fqts_pkg::count_t n_bases;
  fqts_pkg::count_t n_quals;
  fqts_pkg::count_t first_call;
  fqts_pkg::count_t last_call;
  logic             any_call;
  logic [7:0]       q_low;
  logic [7:0]       q_high;
  logic             sanger;
  logic             frozen;
  logic             saturated;

  // Forget everything about the current record.
  task automatic clear_record();
    n_bases    = '0;
    n_quals    = '0;
    first_call = '0;
    last_call  = '0;
    any_call   = 1'b0;
    saturated  = 1'b0;
  endtask

  // Return to the state of a fresh file.
  task automatic restart_file();
    line_kind = fqts_pkg::LkIdle;
    at_start  = 1'b1;
    skip_rest = 1'b0;
    clear_record();
    q_low     = 8'd255;
    q_high    = 8'd0;
    sanger    = 1'b0;
    frozen    = 1'b0;
  endtask

  // Build the report of the record that just ended.
  function automatic trim_report_t make_report(logic flushed);
    trim_report_t r;
    r.bases = fqts_pkg::field_t'(n_bases);
    if (any_call && last_call >= first_call) begin
      r.start = fqts_pkg::field_t'(first_call);
      r.span  = fqts_pkg::field_t'(last_call - first_call + fqts_pkg::count_t'(1));
    end else begin
      r.start = '0;
      r.span  = fqts_pkg::field_t'(1);
    end
    r.q_min     = q_low;
    r.q_max     = q_high;
    r.sanger    = sanger;
    r.flushed   = flushed;
    r.saturated = saturated;
    return r;
  endfunction

  // Advance the scanner by one accepted transfer and queue any report it finishes.
  task automatic scan_item(input logic [7:0] b, input logic eos);
    if (eos) begin
      if (n_bases == n_quals && n_bases != 0) report_q = {report_q, make_report(1'b1)};
      restart_file();
      return;
    end
    if (b == fqts_pkg::ChNewline) begin
      if (sanger) frozen = 1'b1;
      at_start  = 1'b1;
      skip_rest = 1'b0;
      return;
    end
    if (at_start) begin
      at_start  = 1'b0;
      skip_rest = 1'b0;
      if (b == fqts_pkg::ChHeader && n_bases == n_quals) begin
        line_kind = fqts_pkg::LkSeq;
        skip_rest = 1'b1;
        if (n_bases != 0) report_q = {report_q, make_report(1'b0)};
        clear_record();
        return;
      end
      if (b == fqts_pkg::ChPlus && line_kind == fqts_pkg::LkSeq) begin
        line_kind = fqts_pkg::LkQual;
        skip_rest = 1'b1;
        return;
      end
      if (line_kind != fqts_pkg::LkSeq && line_kind != fqts_pkg::LkQual) begin
        skip_rest = 1'b1;
        return;
      end
    end
    if (skip_rest) return;
    if (line_kind == fqts_pkg::LkSeq) begin
      // Bases past the limit only raise the overflow flag.
      if (n_bases >= fqts_pkg::MaxCount) begin
        saturated = 1'b1;
        return;
      end
      if (b != fqts_pkg::ChN) begin
        if (!any_call) begin
          first_call = n_bases;
          any_call   = 1'b1;
        end
        last_call = n_bases;
      end
      n_bases++;
    end else if (line_kind == fqts_pkg::LkQual) begin
      if (!frozen) begin
        if (b < q_low) q_low = b;
        if (b > q_high) q_high = b;
        if (b >= fqts_pkg::SangerLow && b <= fqts_pkg::SangerHigh) sanger = 1'b1;
      end
      if (n_quals >= fqts_pkg::MaxCount) begin
        saturated = 1'b1;
        return;
      end
      n_quals++;
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Predict on accepted bytes, compare on accepted results.
  always @(posedge clk) begin
    trim_report_t want;
    if (rst) begin
      restart_file();
      report_q.delete();
      mismatches = 0;
    end else begin
      if (item_valid === 1'b1 && item_stall === 1'b0) scan_item(data_byte, end_of_stream);
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (report_q.size() == 0) begin
          $display("%0t: result transfer with no record pending, read_length %0d",
                   $time, read_length);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("read_length", want.bases, read_length);
          check_field("trim_start", want.start, trim_start);
          check_field("trim_length", want.span, trim_length);
          check_field("low_quality", 16'(want.q_min), 16'(low_quality));
          check_field("high_quality", 16'(want.q_max), 16'(high_quality));
          check_field("sanger_scale", 16'(want.sanger), 16'(sanger_scale));
          check_field("final_record", 16'(want.flushed), 16'(final_record));
          check_field("length_overflow", 16'(want.saturated), 16'(length_overflow));
        end
      end
    end
    outstanding = report_q.size();
  end

endmodule

FILE: dv/tb_fastq_record_trim_scanner_top.sv
// Testbench top for the FASTQ record trim scanner: clock, reset, byte stimulus, stalls
// and the verdict. Depends on fqts_pkg, fqts_record_checker and the scanner RTL.
module tb_fastq_record_trim_scanner_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        item_valid    = 1'b0;
  logic        item_stall;
  logic [7:0]  data_byte     = 8'd0;
  logic        end_of_stream = 1'b0;
  logic        result_valid;
  logic        result_stall  = 1'b0;
  logic [15:0] read_length;
  logic [15:0] trim_start;
  logic [15:0] trim_length;
  logic [7:0]  low_quality;
  logic [7:0]  high_quality;
  logic        sanger_scale;
  logic        final_record;
  logic        length_overflow;

  int mismatches;
  int outstanding;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;
  // Sequence and quality bytes sent in the random part.
  int payload_bytes = 0;

  fastq_record_trim_scanner_top dut (.*);

  fqts_record_checker checker_i (.*);

  always #10 clk = ~clk;

  // Receiver stalls change at the falling edge.
  always @(negedge clk) result_stall <= ($urandom_range(99) < stall_pct);

  // One transfer on the item channel. Entered and left at a falling edge.
  task automatic send_item(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid    <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // End of stream; the data byte is don't-care.
  task automatic flush_file();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == fqts_pkg::ChNewline) b = b + 8'd1;
    return b;
  endfunction

  // Text after the first byte of a header or plus line.
  task automatic put_junk();
    repeat ($urandom_range(0, 4)) put(any_byte());
  endtask

  // A short file of mostly well-formed records with random content, some noise,
  // some mismatched counts, split and empty lines, usually ended by a flush.
  task automatic random_file();
    int   n_rec;
    int   nb;
    int   nq;
    int   split;
    int   r;
    int   i;
    logic clean_q;
    logic [7:0] b;
    string acgt;
    acgt    = "ACGT";
    n_rec   = $urandom_range(1, 5);
    clean_q = ($urandom_range(1) == 1);
    if ($urandom_range(3) == 0) begin
      put_junk();
      put(fqts_pkg::ChNewline);
    end
    for (r = 0; r < n_rec; r++) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) put(8'($urandom_range(255)));
        continue;
      end
      put(fqts_pkg::ChHeader);
      put_junk();
      put(fqts_pkg::ChNewline);
      nb    = $urandom_range(0, 12);
      split = $urandom_range(1, nb + 4);
      for (i = 0; i < nb; i++) begin
        if (i == split) begin
          put(fqts_pkg::ChNewline);
          if ($urandom_range(3) == 0) put(fqts_pkg::ChNewline);
        end
        case ($urandom_range(9))
          0, 1, 2, 3, 4: b = acgt[$urandom_range(3)];
          5, 6, 7:       b = fqts_pkg::ChN;
          default:       b = any_byte();
        endcase
        put(b);
        payload_bytes++;
      end
      put(fqts_pkg::ChNewline);
      put(fqts_pkg::ChPlus);
      put_junk();
      put(fqts_pkg::ChNewline);
      nq    = ($urandom_range(7) == 0) ? $urandom_range(0, nb + 1) : nb;
      split = $urandom_range(1, nq + 4);
      for (i = 0; i < nq; i++) begin
        if (i == split) put(fqts_pkg::ChNewline);
        b = any_byte();
        // Keep some files free of Sanger symbols so min/max keep moving.
        if (clean_q && b >= fqts_pkg::SangerLow && b <= fqts_pkg::SangerHigh) b = b + 8'd26;
        put(b);
        payload_bytes++;
      end
      if ($urandom_range(7) != 0) put(fqts_pkg::ChNewline);
    end
    if ($urandom_range(3) != 0) flush_file();
  endtask

  // Stimulus.
  initial begin
    int start_bytes;
    int ph;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: a line before any header is ignored, the first header emits nothing.
    put_text("xy");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChHeader);
    put_text("r1");
    put(fqts_pkg::ChNewline);
    put_text("NACN");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChPlus);
    put(fqts_pkg::ChNewline);
    // Quality extremes, no Sanger symbol yet.
    put(8'd0);
    put(8'd255);
    put_text("IJ");
    put(fqts_pkg::ChNewline);
    // Header with matching counts closes the record.
    put(fqts_pkg::ChHeader);
    put(fqts_pkg::ChNewline);
    // Empty line, then an at-sign line while the counts differ counts as bases.
    put(fqts_pkg::ChNewline);
    put_text("NN");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChHeader);
    put_text("A");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChPlus);
    put(fqts_pkg::ChNewline);
    // Sanger symbol; statistics freeze after this line.
    put_text("!5");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChHeader);
    put(8'd1);
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChHeader);
    put(fqts_pkg::ChNewline);
    // Header with no bases, then an all-N read flushed on an unterminated line.
    put(fqts_pkg::ChHeader);
    put(fqts_pkg::ChNewline);
    put_text("NNN");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChPlus);
    put_text("q");
    put(fqts_pkg::ChNewline);
    put_text("+++");
    flush_file();
    // Flush with nothing pending, then a flush with unequal counts.
    flush_file();
    put(fqts_pkg::ChHeader);
    put(fqts_pkg::ChNewline);
    put_text("AC");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChPlus);
    put(fqts_pkg::ChNewline);
    put_text("!");
    flush_file();

    // Random files under four idle and stall patterns.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      start_bytes = payload_bytes;
      while (payload_bytes - start_bytes < 105) random_file();
      flush_file();
    end

    // A short record whose window spans the whole read, closed by a flush.
    idle_pct  = 0;
    stall_pct = 0;
    put(fqts_pkg::ChHeader);
    put(fqts_pkg::ChNewline);
    put_text("ANA");
    put(fqts_pkg::ChNewline);
    put(fqts_pkg::ChPlus);
    put(fqts_pkg::ChNewline);
    put_text("abc");
    put(fqts_pkg::ChNewline);
    flush_file();
    item_valid <= 1'b0;

    // Drain, then allow the pipeline to settle.
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
